// File: src/lts_pkg.sv
// Shared types and constants for the Lisp token scanner.
// Used by the front decoder, the transfer queue and the back-end scanner.
package lts_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 32;

    // Depth of the queue between front and back end (power of two).
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_COMMENT,
        MODE_STRING,
        MODE_ESCAPE,
        MODE_WORD
    } scan_mode_t;

    typedef enum logic [3:0] {
        WC_START,
        WC_SIGN,
        WC_INT,
        WC_DOT,
        WC_FRAC,
        WC_LDOT,
        WC_EXP,
        WC_ESIGN,
        WC_EDIG,
        WC_DEAD
    } word_class_t;

    typedef enum logic [1:0] {
        BM_NONE,
        BM_HASH,
        BM_TRUE,
        BM_FALSE
    } bool_match_t;

    typedef enum logic [1:0] {
        EV_TEXT,
        EV_TOKEN,
        EV_ERROR,
        EV_END
    } event_t;

    typedef enum logic [2:0] {
        TK_LPAREN,
        TK_RPAREN,
        TK_QUOTE,
        TK_STRING,
        TK_SYMBOL,
        TK_INT,
        TK_FLOAT,
        TK_BOOL
    } kind_t;

    localparam logic ERR_BAD_ESCAPE    = 1'b0;
    localparam logic ERR_EOF_IN_STRING = 1'b1;

    // Decoded input byte as it travels through the queue.
    typedef struct packed {
        logic [7:0] ch;
        logic       eof;
        logic       space;
        logic       brk;
        logic       digit;
        logic       sign;
        logic       minus;
        logic       dot;
        logic       e_ch;
        logic       hash;
        logic       t_ch;
        logic       f_ch;
        logic       semi;
        logic       lparen;
        logic       rparen;
        logic       quote;
        logic       dquote;
        logic       bslash;
        logic       newline;
        logic       esc_ok;
        logic [7:0] esc_char;
    } char_info_t;

    typedef struct packed {
        event_t      ev;
        kind_t       kind;
        logic [7:0]  text_char;
        logic [31:0] int_value;
        logic        bool_value;
        logic        error_code;
        logic        last;
    } result_t;

endpackage

// File: src/lts_byte_if.sv
// Input channel of the scanner: one source byte or end-of-input mark per transfer.
// Standalone; no package dependency.
interface lts_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_file;

    modport source (output valid, output in_byte, output end_of_file, input ready);
    modport sink   (input valid, input in_byte, input end_of_file, output ready);
endinterface

// File: src/lts_token_if.sv
// Output channel of the scanner: one result per transfer.
// Standalone; no package dependency.
interface lts_token_if;
    logic               valid;
    logic               ready;
    logic [1:0]         event_res;
    logic [2:0]         token_kind;
    logic [7:0]         text_char;
    logic signed [31:0] int_value;
    logic               bool_value;
    logic               error_code;
    logic               last;

    modport source (output valid, output event_res, output token_kind, output text_char,
                    output int_value, output bool_value, output error_code, output last,
                    input ready);
    modport sink   (input valid, input event_res, input token_kind, input text_char,
                    input int_value, input bool_value, input error_code, input last,
                    output ready);
endinterface

// File: src/lts_front.sv
// Front end: accepts input bytes and decodes their character classes.
// Depends on lts_pkg and lts_byte_if.
module lts_front
(
    lts_byte_if.sink          byte_stream,
    input  logic              full,
    output logic              push,
    output lts_pkg::char_info_t info
);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_LP    = 8'h28;
    localparam logic [7:0] CH_RP    = 8'h29;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LE    = 8'h65;
    localparam logic [7:0] CH_LF_CH = 8'h66;
    localparam logic [7:0] CH_LN    = 8'h6E;
    localparam logic [7:0] CH_LR    = 8'h72;
    localparam logic [7:0] CH_LT    = 8'h74;
    localparam logic [7:0] CH_LV    = 8'h76;

    logic [7:0] c;

    assign c = byte_stream.in_byte;
    assign byte_stream.ready = !full;
    assign push = byte_stream.valid && !full;

    always_comb
    begin
        info = '0;
        info.ch      = c;
        info.eof     = byte_stream.end_of_file;
        info.space   = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
                       (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
        info.semi    = (c == CH_SEMI);
        info.lparen  = (c == CH_LP);
        info.rparen  = (c == CH_RP);
        info.quote   = (c == CH_SQ);
        info.brk     = info.space || info.semi || info.lparen || info.rparen || info.quote;
        info.digit   = (c >= CH_ZERO) && (c <= CH_NINE);
        info.minus   = (c == CH_MINUS);
        info.sign    = (c == CH_PLUS) || info.minus;
        info.dot     = (c == CH_DOT);
        info.e_ch    = (c == CH_LE);
        info.hash    = (c == CH_HASH);
        info.t_ch    = (c == CH_LT);
        info.f_ch    = (c == CH_LF_CH);
        info.dquote  = (c == CH_DQ);
        info.bslash  = (c == CH_BSL);
        info.newline = (c == CH_LF);

        // string escape translation
        info.esc_ok   = 1'b1;
        info.esc_char = 8'h00;
        if (c == CH_BSL)
            info.esc_char = CH_BSL;
        else if (c == CH_DQ)
            info.esc_char = CH_DQ;
        else if (c == CH_LB)
            info.esc_char = CH_BS;
        else if (c == CH_LF_CH)
            info.esc_char = CH_FF;
        else if (c == CH_LN)
            info.esc_char = CH_LF;
        else if (c == CH_LR)
            info.esc_char = CH_CR;
        else if (c == CH_LT)
            info.esc_char = CH_TAB;
        else if (c == CH_LV)
            info.esc_char = CH_VT;
        else
            info.esc_ok = 1'b0;
    end

endmodule

// File: src/lts_fifo.sv
// Short queue of decoded characters between front and back end.
// Depends on lts_pkg.
module lts_fifo
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lts_pkg::char_info_t push_data,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output lts_pkg::char_info_t head_data
);

    lts_pkg::char_info_t                data_reg [lts_pkg::Q_DEPTH];
    logic [lts_pkg::Q_PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [lts_pkg::Q_PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [lts_pkg::Q_CNT_W-1:0]        cnt_reg, cnt_next;

    assign full       = (cnt_reg == lts_pkg::Q_CNT_W'(lts_pkg::Q_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_data  = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? lts_pkg::Q_PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? lts_pkg::Q_PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   cnt_next = lts_pkg::Q_CNT_W'(cnt_reg + 1'b1);
            2'b01:   cnt_next = lts_pkg::Q_CNT_W'(cnt_reg - 1'b1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            data_reg[wr_ptr_reg] <= push_data;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= lts_pkg::Q_CNT_W'(lts_pkg::Q_DEPTH))
        else $error("queue count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

// File: src/lts_back.sv
// Back end: scanner state machine, word classifier and registered result stage.
// Depends on lts_pkg and lts_token_if.
module lts_back
#(
    parameter int VALUE_WIDTH = lts_pkg::DEFAULT_VALUE_WIDTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  lts_pkg::char_info_t head_data,
    output logic                pop,
    lts_token_if.source         token_stream
);

    lts_pkg::scan_mode_t     mode_reg, mode_next;
    lts_pkg::word_class_t    wc_reg, wc_next;
    logic [VALUE_WIDTH-1:0]  acc_reg, acc_next;
    logic                    neg_reg, neg_next;
    lts_pkg::bool_match_t    bm_reg, bm_next;

    logic                    out_valid_reg, out_valid_next;
    logic                    pend_valid_reg, pend_valid_next;
    lts_pkg::result_t        out_reg, pend_reg;

    lts_pkg::char_info_t     q;
    lts_pkg::result_t        r0, r1, fin_res, idle_res;
    logic [1:0]              n_res;
    logic                    idle_hit, idle_start;
    lts_pkg::scan_mode_t     idle_mode;

    logic                    wa_first;
    lts_pkg::word_class_t    base_wc, wa_wc;
    logic [VALUE_WIDTH-1:0]  base_acc, wa_acc;
    logic                    wa_neg;
    lts_pkg::bool_match_t    wa_bm;
    logic [VALUE_WIDTH-1:0]  word_val;
    logic signed [VALUE_WIDTH-1:0] word_val_s;

    logic                    load_ok, load_r0, load_pend, pend_load;

    function automatic lts_pkg::result_t mk_result(lts_pkg::event_t ev, lts_pkg::kind_t kind,
                                                   logic [7:0] ch, logic [31:0] iv,
                                                   logic b, logic err);
        lts_pkg::result_t r;
        r.ev         = ev;
        r.kind       = kind;
        r.text_char  = ch;
        r.int_value  = iv;
        r.bool_value = b;
        r.error_code = err;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic lts_pkg::word_class_t next_class(lts_pkg::word_class_t s,
                                                        lts_pkg::char_info_t ci);
        lts_pkg::word_class_t n;
        n = lts_pkg::WC_DEAD;
        unique case (s)
            lts_pkg::WC_START:
                n = ci.sign  ? lts_pkg::WC_SIGN :
                    ci.digit ? lts_pkg::WC_INT  :
                    ci.dot   ? lts_pkg::WC_LDOT : lts_pkg::WC_DEAD;
            lts_pkg::WC_SIGN:
                n = ci.digit ? lts_pkg::WC_INT  :
                    ci.dot   ? lts_pkg::WC_LDOT : lts_pkg::WC_DEAD;
            lts_pkg::WC_INT:
                n = ci.digit ? lts_pkg::WC_INT :
                    ci.dot   ? lts_pkg::WC_DOT :
                    ci.e_ch  ? lts_pkg::WC_EXP : lts_pkg::WC_DEAD;
            lts_pkg::WC_DOT, lts_pkg::WC_FRAC:
                n = ci.digit ? lts_pkg::WC_FRAC :
                    ci.e_ch  ? lts_pkg::WC_EXP  : lts_pkg::WC_DEAD;
            lts_pkg::WC_LDOT:
                n = ci.digit ? lts_pkg::WC_FRAC : lts_pkg::WC_DEAD;
            lts_pkg::WC_EXP:
                n = ci.sign ? lts_pkg::WC_ESIGN : lts_pkg::WC_DEAD;
            lts_pkg::WC_ESIGN, lts_pkg::WC_EDIG:
                n = ci.digit ? lts_pkg::WC_EDIG : lts_pkg::WC_DEAD;
            default:
                n = lts_pkg::WC_DEAD;
        endcase
        return n;
    endfunction

    assign q = head_data;

    // one character appended to the word (a fresh word when not in word mode)
    assign wa_first = (mode_reg != lts_pkg::MODE_WORD);
    assign base_wc  = wa_first ? lts_pkg::WC_START : wc_reg;
    assign base_acc = wa_first ? '0 : acc_reg;
    assign wa_wc    = next_class(base_wc, q);
    assign wa_neg   = wa_first ? q.minus : neg_reg;

    always_comb
    begin
        if (wa_first)
            wa_bm = q.hash ? lts_pkg::BM_HASH : lts_pkg::BM_NONE;
        else if (bm_reg == lts_pkg::BM_HASH && q.t_ch)
            wa_bm = lts_pkg::BM_TRUE;
        else if (bm_reg == lts_pkg::BM_HASH && q.f_ch)
            wa_bm = lts_pkg::BM_FALSE;
        else
            wa_bm = lts_pkg::BM_NONE;

        if (wa_wc == lts_pkg::WC_INT && q.digit)
            wa_acc = VALUE_WIDTH'((base_acc << 3) + (base_acc << 1) +
                                  VALUE_WIDTH'(q.ch[3:0]));
        else
            wa_acc = base_acc;
    end

    // word token at a break
    assign word_val   = neg_reg ? VALUE_WIDTH'(~acc_reg + 1'b1) : acc_reg;
    assign word_val_s = word_val;

    always_comb
    begin
        if (bm_reg == lts_pkg::BM_TRUE || bm_reg == lts_pkg::BM_FALSE)
            fin_res = mk_result(lts_pkg::EV_TOKEN, lts_pkg::TK_BOOL, 8'h00, 32'h0,
                                bm_reg == lts_pkg::BM_TRUE, 1'b0);
        else if (wc_reg == lts_pkg::WC_INT)
            fin_res = mk_result(lts_pkg::EV_TOKEN, lts_pkg::TK_INT, 8'h00,
                                32'(word_val_s), 1'b0, 1'b0);
        else if (wc_reg == lts_pkg::WC_DOT || wc_reg == lts_pkg::WC_FRAC ||
                 wc_reg == lts_pkg::WC_EDIG)
            fin_res = mk_result(lts_pkg::EV_TOKEN, lts_pkg::TK_FLOAT, 8'h00, 32'h0,
                                1'b0, 1'b0);
        else
            fin_res = mk_result(lts_pkg::EV_TOKEN, lts_pkg::TK_SYMBOL, 8'h00, 32'h0,
                                1'b0, 1'b0);
    end

    // handling of a character between tokens
    always_comb
    begin
        idle_hit   = 1'b0;
        idle_start = 1'b0;
        idle_mode  = lts_pkg::MODE_IDLE;
        idle_res   = mk_result(lts_pkg::EV_TEXT, lts_pkg::TK_LPAREN, 8'h00, 32'h0, 1'b0, 1'b0);
        if (q.eof)
        begin
            idle_hit = 1'b1;
            idle_res = mk_result(lts_pkg::EV_END, lts_pkg::TK_LPAREN, 8'h00, 32'h0,
                                 1'b0, 1'b0);
        end
        else if (q.space)
        begin
            idle_mode = lts_pkg::MODE_IDLE;
        end
        else if (q.semi)
        begin
            idle_mode = lts_pkg::MODE_COMMENT;
        end
        else if (q.lparen || q.rparen || q.quote)
        begin
            idle_hit = 1'b1;
            idle_res = mk_result(lts_pkg::EV_TOKEN,
                                 q.lparen ? lts_pkg::TK_LPAREN :
                                 q.rparen ? lts_pkg::TK_RPAREN : lts_pkg::TK_QUOTE,
                                 8'h00, 32'h0, 1'b0, 1'b0);
        end
        else if (q.dquote)
        begin
            idle_mode = lts_pkg::MODE_STRING;
        end
        else
        begin
            idle_hit   = 1'b1;
            idle_start = 1'b1;
            idle_mode  = lts_pkg::MODE_WORD;
            idle_res   = mk_result(lts_pkg::EV_TEXT, lts_pkg::TK_LPAREN, q.ch, 32'h0,
                                   1'b0, 1'b0);
        end
    end

    // scanner next state and results of the head character
    always_comb
    begin
        mode_next = mode_reg;
        wc_next   = wc_reg;
        acc_next  = acc_reg;
        neg_next  = neg_reg;
        bm_next   = bm_reg;
        n_res     = 2'd0;
        r0        = idle_res;
        r1        = idle_res;

        unique case (mode_reg)
            lts_pkg::MODE_IDLE:
            begin
                mode_next = idle_mode;
                n_res     = {1'b0, idle_hit};
                if (idle_start)
                begin
                    wc_next  = wa_wc;
                    acc_next = wa_acc;
                    neg_next = wa_neg;
                    bm_next  = wa_bm;
                end
            end
            lts_pkg::MODE_COMMENT:
            begin
                if (q.eof)
                begin
                    mode_next = lts_pkg::MODE_IDLE;
                    n_res     = 2'd1;
                    r0        = idle_res;
                end
                else if (q.newline)
                    mode_next = lts_pkg::MODE_IDLE;
            end
            lts_pkg::MODE_STRING:
            begin
                n_res = 2'd1;
                if (q.eof)
                begin
                    mode_next = lts_pkg::MODE_IDLE;
                    r0 = mk_result(lts_pkg::EV_ERROR, lts_pkg::TK_LPAREN, 8'h00, 32'h0,
                                   1'b0, lts_pkg::ERR_EOF_IN_STRING);
                end
                else if (q.dquote)
                begin
                    mode_next = lts_pkg::MODE_IDLE;
                    r0 = mk_result(lts_pkg::EV_TOKEN, lts_pkg::TK_STRING, 8'h00, 32'h0,
                                   1'b0, 1'b0);
                end
                else if (q.bslash)
                begin
                    mode_next = lts_pkg::MODE_ESCAPE;
                    n_res     = 2'd0;
                end
                else
                    r0 = mk_result(lts_pkg::EV_TEXT, lts_pkg::TK_LPAREN, q.ch, 32'h0,
                                   1'b0, 1'b0);
            end
            lts_pkg::MODE_ESCAPE:
            begin
                n_res = 2'd1;
                if (q.eof)
                begin
                    mode_next = lts_pkg::MODE_IDLE;
                    r0 = mk_result(lts_pkg::EV_ERROR, lts_pkg::TK_LPAREN, 8'h00, 32'h0,
                                   1'b0, lts_pkg::ERR_EOF_IN_STRING);
                end
                else if (q.esc_ok)
                begin
                    mode_next = lts_pkg::MODE_STRING;
                    r0 = mk_result(lts_pkg::EV_TEXT, lts_pkg::TK_LPAREN, q.esc_char, 32'h0,
                                   1'b0, 1'b0);
                end
                else
                begin
                    mode_next = lts_pkg::MODE_IDLE;
                    r0 = mk_result(lts_pkg::EV_ERROR, lts_pkg::TK_LPAREN, 8'h00, 32'h0,
                                   1'b0, lts_pkg::ERR_BAD_ESCAPE);
                end
            end
            lts_pkg::MODE_WORD:
            begin
                if (q.eof || q.brk)
                begin
                    // word token, then the break itself as between tokens
                    r0        = fin_res;
                    r1        = idle_res;
                    n_res     = idle_hit ? 2'd2 : 2'd1;
                    mode_next = idle_mode;
                end
                else
                begin
                    wc_next  = wa_wc;
                    acc_next = wa_acc;
                    neg_next = wa_neg;
                    bm_next  = wa_bm;
                    n_res    = 2'd1;
                    r0 = mk_result(lts_pkg::EV_TEXT, lts_pkg::TK_LPAREN, q.ch, 32'h0,
                                   1'b0, 1'b0);
                end
            end
            default:
                mode_next = lts_pkg::MODE_IDLE;
        endcase

        if (n_res == 2'd1)
            r0.last = 1'b1;
        if (n_res == 2'd2)
            r1.last = 1'b1;
    end

    // output register with one pending slot for the second result
    assign load_ok = !out_valid_reg || token_stream.ready;

    always_comb
    begin
        pop             = 1'b0;
        load_r0         = 1'b0;
        load_pend       = 1'b0;
        pend_load       = 1'b0;
        out_valid_next  = out_valid_reg && !token_stream.ready;
        pend_valid_next = pend_valid_reg;
        if (pend_valid_reg)
        begin
            if (load_ok)
            begin
                load_pend       = 1'b1;
                out_valid_next  = 1'b1;
                pend_valid_next = 1'b0;
            end
        end
        else if (head_valid)
        begin
            if (n_res == 2'd0)
                pop = 1'b1;
            else if (load_ok)
            begin
                pop            = 1'b1;
                load_r0        = 1'b1;
                out_valid_next = 1'b1;
                if (n_res == 2'd2)
                begin
                    pend_load       = 1'b1;
                    pend_valid_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= lts_pkg::MODE_IDLE;
            wc_reg         <= lts_pkg::WC_START;
            acc_reg        <= '0;
            neg_reg        <= 1'b0;
            bm_reg         <= lts_pkg::BM_NONE;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                mode_reg <= mode_next;
                wc_reg   <= wc_next;
                acc_reg  <= acc_next;
                neg_reg  <= neg_next;
                bm_reg   <= bm_next;
            end
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_pend)
            out_reg <= pend_reg;
        else if (load_r0)
            out_reg <= r0;
        if (pend_load)
            pend_reg <= r1;
    end

    assign token_stream.valid      = out_valid_reg;
    assign token_stream.event_res  = out_reg.ev;
    assign token_stream.token_kind = out_reg.kind;
    assign token_stream.text_char  = out_reg.text_char;
    assign token_stream.int_value  = out_reg.int_value;
    assign token_stream.bool_value = out_reg.bool_value;
    assign token_stream.error_code = out_reg.error_code;
    assign token_stream.last       = out_reg.last;

    assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("second result pending with empty output register");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && pend_valid_reg))
        else $error("character consumed while a result is still pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == lts_pkg::MODE_ESCAPE && $past(mode_reg) != lts_pkg::MODE_ESCAPE) |->
        ($past(mode_reg) == lts_pkg::MODE_STRING))
        else $error("escape mode entered from outside a string");

endmodule

// File: src/lisp_token_scanner_top.sv
// Lisp token scanner, top level: front decoder, queue and back-end scanner.
// Depends on lts_pkg, lts_byte_if, lts_token_if, lts_front, lts_fifo, lts_back.
//
// The scanner takes one source byte (or an end-of-input mark) per transfer on
// byte_stream and returns text characters, tokens, errors and end-of-input
// results on token_stream, each with last set on the final result a byte caused.
// A new byte is taken every cycle while the queue has room: the front end decodes
// the character classes and writes them into a two-entry queue; the back end runs
// the scanner state machine on the queue head and places results in an output
// register. Bytes that give one result or none retire at one per cycle while the
// output is not stalled. A break character or end of input that closes a word and
// also gives a token of its own yields two results; the back end takes no new
// byte until the second has moved from the pending slot into the output register.
// Integer words accumulate in a VALUE_WIDTH-bit register (wrapping silently);
// the token value is that register, negated for a leading minus, sign-extended
// or cut to 32 bits. The atof value of a float is not produced, only its text.
module lisp_token_scanner_top
#(
    parameter int VALUE_WIDTH = lts_pkg::DEFAULT_VALUE_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    lts_byte_if.sink    byte_stream,
    lts_token_if.source token_stream
);

    lts_pkg::char_info_t front_info;
    lts_pkg::char_info_t head_data;
    logic                push;
    logic                full;
    logic                pop;
    logic                head_valid;

    // byte decode; ready follows queue space only
    lts_front u_front
    (
        .byte_stream (byte_stream),
        .full        (full),
        .push        (push),
        .info        (front_info)
    );

    // decouples the two halves so a stalled output does not stop intake at once
    lts_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (front_info),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    // scanner state, word classification and result register
    lts_back
    #(
        .VALUE_WIDTH (VALUE_WIDTH)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_data    (head_data),
        .pop          (pop),
        .token_stream (token_stream)
    );

endmodule

// File: tb/testbench.sv
// Self-checking bench for lisp_token_scanner_top: random byte streams in, checked results out.
// Depends on lts_pkg, lts_byte_if, lts_token_if and the scanner RTL under src.
module testbench;
    import lts_pkg::*;

    localparam int VW           = DEFAULT_VALUE_WIDTH;
    localparam int RANDOM_ITEMS = 1300;
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_EVERY   = 900;    // cycles between long receiver hold-offs
    localparam int HOLD_CYCLES  = 96;     // length of one hold-off
    localparam int SETTLE       = 8;      // quiet cycles after the last result

    // Control characters the scanner treats specially.
    localparam logic [7:0] CH_BKSP = 8'h08;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_VT   = 8'h0B;
    localparam logic [7:0] CH_FF   = 8'h0C;
    localparam logic [7:0] CH_CR   = 8'h0D;

    // token_kind reads zero on results that are not tokens.
    localparam kind_t NO_KIND = TK_LPAREN;

    typedef struct packed {
        logic [7:0] ch;
        logic       eof;
    } source_item_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Bench-side copies of the DUT inputs; known from time zero.
    logic       in_valid  = 1'b0;
    logic [7:0] in_byte   = 8'h00;
    logic       in_eof    = 1'b0;
    logic       out_ready = 1'b0;

    lts_byte_if  byte_bus ();
    lts_token_if token_bus ();

    assign byte_bus.valid       = in_valid;
    assign byte_bus.in_byte     = in_byte;
    assign byte_bus.end_of_file = in_eof;
    assign token_bus.ready      = out_ready;

    lisp_token_scanner_top #(.VALUE_WIDTH(VW)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_stream  (byte_bus),
        .token_stream (token_bus)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Scanner state as the bench tracks it
    // ------------------------------------------------------------------
    scan_mode_t    sc_mode  = MODE_IDLE;
    word_class_t   sc_class = WC_START;
    logic [VW-1:0] sc_acc   = '0;
    logic          sc_neg   = 1'b0;
    bool_match_t   sc_bool  = BM_NONE;

    source_item_t source_bytes[$];   // bytes still to be offered
    result_t      results_due[$];    // results the DUT still owes, oldest first

    int fed_items     = 0;
    int bytes_taken   = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int event_count[4];
    int kind_count[8];
    logic byte_took   = 1'b0;        // a byte transfer happened at the last rising edge

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c == " " || c == CH_FF || c == CH_LF || c == CH_CR || c == CH_TAB || c == CH_VT;
    endfunction

    function automatic logic is_break(logic [7:0] c);
        return is_space(c) || c == "(" || c == ")" || c == "'" || c == ";";
    endfunction

    // {valid, translated char} for the byte after a backslash.
    function automatic logic [8:0] escape_char(logic [7:0] c);
        case (c)
            "\\":    return {1'b1, 8'h5C};
            "\"":    return {1'b1, 8'h22};
            "b":     return {1'b1, CH_BKSP};
            "f":     return {1'b1, CH_FF};
            "n":     return {1'b1, CH_LF};
            "r":     return {1'b1, CH_CR};
            "t":     return {1'b1, CH_TAB};
            "v":     return {1'b1, CH_VT};
            default: return 9'h000;
        endcase
    endfunction

    // Number recognizer: sign, digits, dot, fraction, exponent.
    function automatic word_class_t next_wc(word_class_t s, logic [7:0] c);
        logic d;
        logic sg;
        d  = is_digit(c);
        sg = (c == "+") || (c == "-");
        case (s)
            WC_START:        return sg ? WC_SIGN : d ? WC_INT : (c == ".") ? WC_LDOT : WC_DEAD;
            WC_SIGN:         return d ? WC_INT : (c == ".") ? WC_LDOT : WC_DEAD;
            WC_INT:          return d ? WC_INT : (c == ".") ? WC_DOT
                                               : (c == "e") ? WC_EXP : WC_DEAD;
            WC_DOT, WC_FRAC: return d ? WC_FRAC : (c == "e") ? WC_EXP : WC_DEAD;
            WC_LDOT:         return d ? WC_FRAC : WC_DEAD;
            WC_EXP:          return sg ? WC_ESIGN : WC_DEAD;
            WC_ESIGN,
            WC_EDIG:         return d ? WC_EDIG : WC_DEAD;
            default:         return WC_DEAD;
        endcase
    endfunction

    function automatic result_t make_result(event_t ev, kind_t k, logic [7:0] ch,
                                            logic [31:0] iv, logic b, logic err);
        result_t r;
        r.ev         = ev;
        r.kind       = k;
        r.text_char  = ch;
        r.int_value  = iv;
        r.bool_value = b;
        r.error_code = err;
        r.last       = 1'b0;
        return r;
    endfunction

    task automatic add_word_char(input logic [7:0] c);
        logic first;
        first = (sc_class == WC_START);
        // #t / #f tracking: only a two-character word can match
        if (first)
            sc_bool = (c == "#") ? BM_HASH : BM_NONE;
        else if (sc_bool == BM_HASH && c == "t")
            sc_bool = BM_TRUE;
        else if (sc_bool == BM_HASH && c == "f")
            sc_bool = BM_FALSE;
        else
            sc_bool = BM_NONE;
        if (first && c == "-")
            sc_neg = 1'b1;
        sc_class = next_wc(sc_class, c);
        if (sc_class == WC_INT && is_digit(c))
            sc_acc = sc_acc * 10 + (c - "0");   // wraps at VW bits
    endtask

    task automatic close_word();
        logic [VW-1:0] mag;
        sc_mode = MODE_IDLE;
        if (sc_bool == BM_TRUE || sc_bool == BM_FALSE)
            results_due.push_back(make_result(EV_TOKEN, TK_BOOL, 8'h00, 32'h0,
                                              sc_bool == BM_TRUE, 1'b0));
        else if (sc_class == WC_INT)
        begin
            mag = sc_neg ? -sc_acc : sc_acc;
            results_due.push_back(make_result(EV_TOKEN, TK_INT, 8'h00,
                                              32'(signed'(mag)), 1'b0, 1'b0));
        end
        else if (sc_class == WC_DOT || sc_class == WC_FRAC || sc_class == WC_EDIG)
            results_due.push_back(make_result(EV_TOKEN, TK_FLOAT, 8'h00, 32'h0, 1'b0, 1'b0));
        else
            results_due.push_back(make_result(EV_TOKEN, TK_SYMBOL, 8'h00, 32'h0, 1'b0, 1'b0));
    endtask

    task automatic idle_byte(input logic [7:0] c, input logic eof);
        sc_mode = MODE_IDLE;
        if (eof)
            results_due.push_back(make_result(EV_END, NO_KIND, 8'h00, 32'h0, 1'b0, 1'b0));
        else if (!is_space(c))
        begin
            case (c)
                ";":  sc_mode = MODE_COMMENT;
                "(":  results_due.push_back(make_result(EV_TOKEN, TK_LPAREN, 8'h00, 32'h0,
                                                        1'b0, 1'b0));
                ")":  results_due.push_back(make_result(EV_TOKEN, TK_RPAREN, 8'h00, 32'h0,
                                                        1'b0, 1'b0));
                "'":  results_due.push_back(make_result(EV_TOKEN, TK_QUOTE, 8'h00, 32'h0,
                                                        1'b0, 1'b0));
                "\"": sc_mode = MODE_STRING;
                default:
                begin
                    sc_class = WC_START;
                    sc_bool  = BM_NONE;
                    sc_acc   = '0;
                    sc_neg   = 1'b0;
                    add_word_char(c);
                    sc_mode  = MODE_WORD;
                    results_due.push_back(make_result(EV_TEXT, NO_KIND, c, 32'h0, 1'b0, 1'b0));
                end
            endcase
        end
    endtask

    // Works out what one accepted byte produces; the final result gets last.
    task automatic scan_byte(input logic [7:0] c, input logic eof);
        int       before_cnt;
        logic [8:0] esc;
        result_t  r;
        before_cnt = results_due.size();
        case (sc_mode)
            MODE_COMMENT:
                if (eof)
                    idle_byte(c, 1'b1);
                else if (c == CH_LF)
                    sc_mode = MODE_IDLE;
            MODE_STRING:
                if (eof)
                begin
                    sc_mode = MODE_IDLE;
                    results_due.push_back(make_result(EV_ERROR, NO_KIND, 8'h00, 32'h0,
                                                      1'b0, ERR_EOF_IN_STRING));
                end
                else if (c == "\"")
                begin
                    sc_mode = MODE_IDLE;
                    results_due.push_back(make_result(EV_TOKEN, TK_STRING, 8'h00, 32'h0,
                                                      1'b0, 1'b0));
                end
                else if (c == "\\")
                    sc_mode = MODE_ESCAPE;
                else
                    results_due.push_back(make_result(EV_TEXT, NO_KIND, c, 32'h0, 1'b0, 1'b0));
            MODE_ESCAPE:
            begin
                esc = escape_char(c);
                if (eof)
                begin
                    sc_mode = MODE_IDLE;
                    results_due.push_back(make_result(EV_ERROR, NO_KIND, 8'h00, 32'h0,
                                                      1'b0, ERR_EOF_IN_STRING));
                end
                else if (esc[8])
                begin
                    sc_mode = MODE_STRING;
                    results_due.push_back(make_result(EV_TEXT, NO_KIND, esc[7:0], 32'h0,
                                                      1'b0, 1'b0));
                end
                else
                begin
                    sc_mode = MODE_IDLE;
                    results_due.push_back(make_result(EV_ERROR, NO_KIND, 8'h00, 32'h0,
                                                      1'b0, ERR_BAD_ESCAPE));
                end
            end
            MODE_WORD:
                if (eof || is_break(c))
                begin
                    // word token first, then the break char (or end of input) itself
                    close_word();
                    idle_byte(c, eof);
                end
                else
                begin
                    add_word_char(c);
                    results_due.push_back(make_result(EV_TEXT, NO_KIND, c, 32'h0, 1'b0, 1'b0));
                end
            default:
                idle_byte(c, eof);
        endcase
        if (results_due.size() > before_cnt)
        begin
            r = results_due.pop_back();
            r.last = 1'b1;
            results_due.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] result %0d: %s got 0x%0h, wanted 0x%0h",
                 $time, results_seen, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b, input bit counts = 1'b1);
        source_item_t it;
        it.ch  = b;
        it.eof = 1'b0;
        source_bytes.push_back(it);
        if (counts)
            fed_items++;
    endtask

    task automatic push_eof();
        source_item_t it;
        it.ch  = 8'($urandom_range(0, 255));   // the byte lane is don't-care here
        it.eof = 1'b1;
        source_bytes.push_back(it);
        fed_items++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    task automatic push_digits(input int n);
        for (int i = 0; i < n; i++)
            push_byte(8'("0" + $urandom_range(0, 9)));
    endtask

    task automatic push_sign();
        push_byte($urandom_range(0, 1) ? "+" : "-");
    endtask

    function automatic logic [7:0] rand_word_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (is_break(c));
        return c;
    endfunction

    // Comment body without its newline.
    task automatic push_comment_body();
        logic [7:0] c;
        repeat ($urandom_range(0, 6))
        begin
            do
                c = 8'($urandom_range(0, 255));
            while (c == CH_LF);
            push_byte(c, 1'b0);
        end
    endtask

    // What follows a word: a break character of some kind, or end of input.
    task automatic end_word();
        case ($urandom_range(0, 11))
            0:       push_eof();
            1:       push_byte("(");
            2:       push_byte(")");
            3:       push_byte("'");
            4:
            begin
                push_byte(";");
                push_comment_body();
                push_byte(CH_LF, 1'b0);
            end
            5:       push_byte(CH_TAB);
            6:       push_byte(CH_LF);
            7:       push_byte(CH_CR);
            8:       push_byte(CH_VT);
            9:       push_byte(CH_FF);
            default: push_byte(" ");
        endcase
    endtask

    task automatic push_string_lit();
        logic [7:0] c;
        int         n;
        bit         broken;
        n      = $urandom_range(0, 8);
        broken = 1'b0;
        push_byte("\"");
        for (int i = 0; i < n && !broken; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                push_byte("\\");
                if ($urandom_range(0, 9) == 0)
                begin
                    // unsupported escape ends the string with an error
                    do
                        c = 8'($urandom_range(0, 255));
                    while (escape_char(c) != 9'h000);
                    push_byte(c);
                    broken = 1'b1;
                end
                else
                begin
                    case ($urandom_range(0, 7))
                        0:       push_byte("\\");
                        1:       push_byte("\"");
                        2:       push_byte("b");
                        3:       push_byte("f");
                        4:       push_byte("n");
                        5:       push_byte("r");
                        6:       push_byte("t");
                        default: push_byte("v");
                    endcase
                end
            end
            else
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c == "\"" || c == "\\");
                push_byte(c);
            end
        end
        if (!broken)
        begin
            case ($urandom_range(0, 19))
                0:       push_eof();
                1:
                begin
                    push_byte("\\");        // end of input right after a backslash
                    push_eof();
                end
                default: push_byte("\"");
            endcase
        end
    endtask

    task automatic push_float();
        if ($urandom_range(0, 3) == 0)
            push_sign();
        if ($urandom_range(0, 2) == 0)
        begin
            push_byte(".");
            push_digits($urandom_range(1, 3));
        end
        else
        begin
            push_digits($urandom_range(1, 4));
            if ($urandom_range(0, 3) != 0)
                push_byte(".");
            push_digits($urandom_range(0, 3));
        end
        if ($urandom_range(0, 1))
        begin
            push_byte("e");
            if ($urandom_range(0, 3) != 0)
                push_sign();
            push_digits($urandom_range(0, 2));
        end
    endtask

    task automatic push_symbol();
        logic [7:0] c;
        if ($urandom_range(0, 2) == 0)
        begin
            // near misses of numbers and booleans
            case ($urandom_range(0, 14))
                0:       push_text("+");
                1:       push_text("-");
                2:       push_text(".");
                3:       push_text("e5");
                4:       push_text("1e5");
                5:       push_text("1.2e");
                6:       push_text("1.2e+");
                7:       push_text("+.");
                8:       push_text("-.5x");
                9:       push_text("1.2.3");
                10:      push_text("#");
                11:      push_text("#tt");
                12:      push_text("##f");
                13:      push_text("#T");
                default: push_text("a\"b");
            endcase
        end
        else
        begin
            do
                c = rand_word_char();
            while (c == "\"");
            push_byte(c);
            repeat ($urandom_range(0, 5))
                push_byte(rand_word_char());
        end
    endtask

    task automatic push_integer();
        if ($urandom_range(0, 5) == 0)
        begin
            case ($urandom_range(0, 7))
                0:       push_text("2147483647");
                1:       push_text("2147483648");
                2:       push_text("-2147483648");
                3:       push_text("4294967295");
                4:       push_text("4294967296");
                5:       push_text("-0");
                6:       push_text("+0");
                default: push_text("99999999999999");
            endcase
        end
        else
        begin
            if ($urandom_range(0, 2) == 0)
                push_sign();
            push_digits(($urandom_range(0, 3) == 0) ? $urandom_range(1, 14)
                                                     : $urandom_range(1, 4));
        end
    endtask

    // One random lexical piece; mostly well formed, some noise.
    task automatic add_piece();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            repeat ($urandom_range(1, 3))
                case ($urandom_range(0, 5))
                    0:       push_byte(CH_TAB, 1'b0);
                    1:       push_byte(CH_LF, 1'b0);
                    2:       push_byte(CH_CR, 1'b0);
                    3:       push_byte(CH_VT, 1'b0);
                    4:       push_byte(CH_FF, 1'b0);
                    default: push_byte(" ", 1'b0);
                endcase
        end
        else if (pick < 18)
            case ($urandom_range(0, 2))
                0:       push_byte("(");
                1:       push_byte(")");
                default: push_byte("'");
            endcase
        else if (pick < 24)
        begin
            push_byte(";");
            push_comment_body();
            if ($urandom_range(0, 7) == 0)
                push_eof();
            else
                push_byte(CH_LF, 1'b0);
        end
        else if (pick < 42)
            push_string_lit();
        else if (pick < 56)
        begin
            push_integer();
            end_word();
        end
        else if (pick < 68)
        begin
            push_float();
            end_word();
        end
        else if (pick < 74)
        begin
            push_text($urandom_range(0, 1) ? "#t" : "#f");
            end_word();
        end
        else if (pick < 90)
        begin
            push_symbol();
            end_word();
        end
        else
        begin
            // raw noise, end of input included
            repeat ($urandom_range(1, 3))
                if ($urandom_range(0, 4) == 0)
                    push_eof();
                else
                    push_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of transfers with random gaps between them.
    // valid stays up until the byte is taken; the next byte is put out
    // on the falling edge right after the transfer, unless a gap follows.
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge clk)
    begin
        source_item_t it;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || byte_took)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (source_bytes.size() > 0)
            begin
                it = source_bytes.pop_front();
                in_byte  <= it.ch;
                in_eof   <= it.eof;
                in_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left--;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: a stall style that changes every so often, plus a long
    // hold-off now and then so that the queue inside fills and the
    // scanner pushes back on its input.
    // ------------------------------------------------------------------
    logic holding    = 1'b0;
    int   hold_left  = 0;
    int   hold_timer = HOLD_EVERY / 2;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                holding = (hold_left != 0);
            end
            else if (hold_timer >= HOLD_EVERY)
            begin
                hold_timer = 0;
                hold_left  = HOLD_CYCLES;
                holding    = 1'b1;
            end
            else
                hold_timer++;
        end
    end

    int stall_tick  = 0;
    int stall_style = 0;

    always @(negedge clk)
    begin
        logic rdy;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            stall_tick++;
            if (stall_tick % 250 == 0)
                stall_style = $urandom_range(0, 3);
            case (stall_style)
                0:       rdy = 1'b1;                          // no stalls at all
                1:       rdy = 1'($urandom_range(0, 1));
                2:       rdy = (stall_tick % 4 == 0);         // one transfer in four
                default: rdy = ($urandom_range(0, 7) != 0);
            endcase
            out_ready <= rdy && !holding;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: byte transfers feed the prediction, result transfers are
    // checked field by field against the oldest result due.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        byte_took = 1'b0;
        if (rst_n)
        begin
            if (byte_bus.valid && byte_bus.ready)
            begin
                scan_byte(byte_bus.in_byte, byte_bus.end_of_file);
                bytes_taken++;
                byte_took = 1'b1;
            end
            if (token_bus.valid && token_bus.ready)
            begin
                results_seen++;
                event_count[token_bus.event_res]++;
                if (token_bus.event_res == EV_TOKEN)
                    kind_count[token_bus.token_kind]++;
                if (results_due.size() == 0)
                    report_mismatch("result with none due, event", 32'(token_bus.event_res),
                                    32'h0);
                else
                begin
                    want = results_due.pop_front();
                    if (token_bus.event_res !== want.ev)
                        report_mismatch("event_res", 32'(token_bus.event_res), 32'(want.ev));
                    if (token_bus.token_kind !== want.kind)
                        report_mismatch("token_kind", 32'(token_bus.token_kind),
                                        32'(want.kind));
                    if (token_bus.text_char !== want.text_char)
                        report_mismatch("text_char", 32'(token_bus.text_char),
                                        32'(want.text_char));
                    if (token_bus.int_value !== want.int_value)
                        report_mismatch("int_value", token_bus.int_value, want.int_value);
                    if (token_bus.bool_value !== want.bool_value)
                        report_mismatch("bool_value", 32'(token_bus.bool_value),
                                        32'(want.bool_value));
                    if (token_bus.error_code !== want.error_code)
                        report_mismatch("error_code", 32'(token_bus.error_code),
                                        32'(want.error_code));
                    if (token_bus.last !== want.last)
                        report_mismatch("last", 32'(token_bus.last), 32'(want.last));
                end
            end
        end
    end

    // Hard stop in case the scanner hangs.
    initial
    begin
        #(LIMIT_CYCLES * 4);
        $display("lisp_token_scanner_top: mismatch");
        $finish;
    end

    initial
    begin
        foreach (event_count[i])
            event_count[i] = 0;
        foreach (kind_count[i])
            kind_count[i] = 0;

        // Directed opener: a small list with an integer and a float, a quote token,
        // a double quote and the extreme bytes inside a word, a comment,
        // a good and a bad escape, then end of input inside an escape.
        push_text("(#t -12 .5e+3)");
        push_text("'a\"b");
        push_byte(8'hFF);
        push_byte(8'h00);
        push_text(";c\n");
        push_text("\"\\n\\q");
        push_text("\"\\");
        push_eof();

        fed_items = 0;
        while (fed_items < RANDOM_ITEMS)
            add_piece();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // drain: every byte taken, then every result back
        while (source_bytes.size() > 0 || in_valid)
            @(posedge clk);
        while (results_due.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Scanned %0d bytes into %0d results: %0d text, %0d tokens, %0d errors, %0d ends",
                 bytes_taken, results_seen, event_count[EV_TEXT], event_count[EV_TOKEN],
                 event_count[EV_ERROR], event_count[EV_END]);
        $display("Tokens by kind ( ) ' str sym int float bool: %0d %0d %0d %0d %0d %0d %0d %0d",
                 kind_count[TK_LPAREN], kind_count[TK_RPAREN], kind_count[TK_QUOTE],
                 kind_count[TK_STRING], kind_count[TK_SYMBOL], kind_count[TK_INT],
                 kind_count[TK_FLOAT], kind_count[TK_BOOL]);
        if (mismatches == 0)
            $display("lisp_token_scanner_top: match");
        else
            $display("lisp_token_scanner_top: mismatch");
        $finish;
    end
endmodule

// File: filelist.f
src/lts_pkg.sv
src/lts_byte_if.sv
src/lts_token_if.sv
src/lts_front.sv
src/lts_fifo.sv
src/lts_back.sv
src/lisp_token_scanner_top.sv
tb/testbench.sv
